// File: sv/mtcm_pkg.sv
`default_nettype none

package mtcm_pkg;

  // table geometry
  localparam int TableDepth = 128;
  localparam int AddrW      = $clog2(TableDepth);
  localparam int EntryW     = 3;

  // item operation codes
  typedef enum logic [1:0] {
    OP_MIDI   = 2'd0,
    OP_KEY_WR = 2'd1,
    OP_CTL_WR = 2'd2,
    OP_UNUSED = 2'd3
  } op_t;

  // configuration register indexes
  localparam logic [1:0] CFG_LISTEN_ENABLE    = 2'd0;
  localparam logic [1:0] CFG_CHANNEL_FILTER   = 2'd1;
  localparam logic [1:0] CFG_REQUIRE_MODIFIER = 2'd2;

  // midi message kinds (upper status nibble)
  localparam logic [3:0] KIND_NOTE_OFF  = 4'h8;
  localparam logic [3:0] KIND_NOTE_ON   = 4'h9;
  localparam logic [3:0] KIND_CTRL_CHG  = 4'hB;

  // channel filter value that accepts every channel
  localparam logic signed [4:0] FILTER_ALL = -5'sd1;

  // table entry codes
  localparam logic [EntryW-1:0] ACT_NONE        = 3'd0;
  localparam logic [EntryW-1:0] ACT_CONTROL     = 3'd1;
  localparam logic [EntryW-1:0] ACT_PLAY        = 3'd2;
  localparam logic [EntryW-1:0] ACT_STOP        = 3'd3;
  localparam logic [EntryW-1:0] ACT_TOGGLE_LOOP = 3'd4;
  localparam logic [EntryW-1:0] ACT_LOOP_START  = 3'd5;
  localparam logic [EntryW-1:0] ACT_LOOP_END    = 3'd6;

  // preset table locations
  localparam logic [AddrW-1:0] KEY_MODIFIER    = 7'd60;
  localparam logic [AddrW-1:0] KEY_PLAY        = 7'd57;
  localparam logic [AddrW-1:0] KEY_STOP        = 7'd59;
  localparam logic [AddrW-1:0] KEY_TOGGLE_LOOP = 7'd58;
  localparam logic [AddrW-1:0] CTL_PLAY        = 7'd24;
  localparam logic [AddrW-1:0] CTL_STOP        = 7'd23;

  typedef struct packed {
    logic              listen_enable;
    logic signed [4:0] channel_filter;
    logic              require_modifier;
  } cfg_t;

  // item held between the input register and the result register
  typedef struct packed {
    op_t        op;
    logic [7:0] status_byte;
    logic [6:0] data_two;
  } item_t;

  typedef struct packed {
    logic              fire;
    logic [2:0]        action;
  } result_t;

  // key table contents after reset
  function automatic logic [EntryW-1:0] key_reset_entry(input logic [AddrW-1:0] addr);
    logic [EntryW-1:0] e;
    case (addr)
      KEY_MODIFIER:    e = ACT_CONTROL;
      KEY_PLAY:        e = ACT_PLAY;
      KEY_STOP:        e = ACT_STOP;
      KEY_TOGGLE_LOOP: e = ACT_TOGGLE_LOOP;
      default:         e = ACT_NONE;
    endcase
    return e;
  endfunction

  // controller table contents after reset
  function automatic logic [EntryW-1:0] ctl_reset_entry(input logic [AddrW-1:0] addr);
    logic [EntryW-1:0] e;
    case (addr)
      CTL_PLAY: e = ACT_PLAY;
      CTL_STOP: e = ACT_STOP;
      default:  e = ACT_NONE;
    endcase
    return e;
  endfunction

endpackage

`default_nettype wire

// File: sv/mtcm_ram.sv
`default_nettype none

module mtcm_ram #(
  parameter int Width = 3,
  parameter int Depth = 128
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(Depth)-1:0] waddr,
  input  wire logic [Width-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(Depth)-1:0] raddr,
  output logic      [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// File: sv/mtcm_table.sv
`default_nettype none

module mtcm_table (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             wr_en,
  input  wire logic [mtcm_pkg::AddrW-1:0]       wr_addr,
  input  wire logic [mtcm_pkg::EntryW-1:0]      wr_data,
  input  wire logic                             rd_en,
  input  wire logic [mtcm_pkg::AddrW-1:0]       rd_addr,
  input  wire logic [mtcm_pkg::EntryW-1:0]      rd_default,
  output logic      [mtcm_pkg::EntryW-1:0]      rd_data
);

  logic [mtcm_pkg::TableDepth-1:0] written;
  logic                            hit;
  logic [mtcm_pkg::EntryW-1:0]     preset;
  logic [mtcm_pkg::EntryW-1:0]     ram_q;

  mtcm_ram #(
    .Width (mtcm_pkg::EntryW),
    .Depth (mtcm_pkg::TableDepth)
  ) u_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (wr_data),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (ram_q)
  );

  // per-entry written flags, cleared by reset
  always_ff @(posedge clk) begin
    if (rst) begin
      written <= '0;
    end else if (wr_en) begin
      written[wr_addr] <= 1'b1;
    end
  end

  // sample flag and preset value alongside the ram read
  always_ff @(posedge clk) begin
    if (rst) begin
      hit <= 1'b0;
    end else if (rd_en) begin
      hit <= written[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      preset <= rd_default;
    end
  end

  assign rd_data = hit ? ram_q : preset;

endmodule

`default_nettype wire

// File: sv/mtcm_eval.sv
`default_nettype none

module mtcm_eval (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        advance,
  input  wire mtcm_pkg::item_t             item,
  input  wire logic [mtcm_pkg::EntryW-1:0] key_entry,
  input  wire logic [mtcm_pkg::EntryW-1:0] ctl_entry,
  input  wire mtcm_pkg::cfg_t              cfg,
  output mtcm_pkg::result_t                result
);

  logic [7:0]                  held_count;
  logic [7:0]                  held_count_next;
  logic [3:0]                  kind;
  logic [3:0]                  chan;
  logic                        msg_ok;
  logic                        note_on;
  logic                        ctrl_chg;
  logic                        vel_nz;
  logic                        modifier_key;
  logic                        key_allowed;
  logic [mtcm_pkg::EntryW-1:0] entry;
  logic                        fires;

  assign kind   = item.status_byte[7:4];
  assign chan   = item.status_byte[3:0];
  assign vel_nz = (item.data_two != 7'd0);

  // message gating: op, listening, channel
  always_comb begin
    msg_ok = (item.op == mtcm_pkg::OP_MIDI) && cfg.listen_enable &&
             ((cfg.channel_filter == mtcm_pkg::FILTER_ALL) ||
              ($unsigned(cfg.channel_filter) == {1'b0, chan}));
    note_on  = msg_ok && (kind == mtcm_pkg::KIND_NOTE_ON);
    ctrl_chg = msg_ok && (kind == mtcm_pkg::KIND_CTRL_CHG);
  end

  assign modifier_key = note_on && (key_entry == mtcm_pkg::ACT_CONTROL);
  assign key_allowed  = !cfg.require_modifier || (held_count != 8'd0);

  // pick the entry that may fire
  always_comb begin
    entry = ctrl_chg ? ctl_entry : key_entry;
    fires = 1'b0;
    if (note_on && !modifier_key && vel_nz && key_allowed) begin
      fires = 1'b1;
    end else if (ctrl_chg && vel_nz) begin
      fires = 1'b1;
    end
    result.fire   = fires && (entry >= mtcm_pkg::ACT_PLAY) &&
                    (entry <= mtcm_pkg::ACT_LOOP_END);
    result.action = entry - mtcm_pkg::ACT_PLAY;
  end

  // held modifier count, saturating up and flooring down
  always_comb begin
    held_count_next = held_count;
    if (advance && modifier_key) begin
      if (vel_nz) begin
        if (held_count != 8'hFF) begin
          held_count_next = held_count + 8'd1;
        end
      end else if (held_count != 8'd0) begin
        held_count_next = held_count - 8'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_count <= 8'd0;
    end else begin
      held_count <= held_count_next;
    end
  end

endmodule

`default_nettype wire

// File: sv/midi_transport_command_mapper_core.sv
`default_nettype none

// MIDI transport command mapper. Each transaction on the input channel is a
// MIDI message (op 0) or a write to the key or controller action table (op 1,
// op 2); a message gives at most one transport action code on the output
// channel. A transaction is taken every cycle unless in_stall is high: the
// table read at data_one is registered with the input register, the decision
// and modifier count update come from that register, and the result sits in
// an output register; a table write is seen by the very next message. Input
// stall rises only when a result is ready while the output register is still
// stalled. Both tables come out of reset with their preset entries, with no
// clearing pass. Configuration is written through config_write, config_index
// and config_data (index 0 listen enable, 1 channel filter, 2 require
// modifier); the user must write it only while the block is idle, unenforced.
module midi_transport_command_mapper_core (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       config_write,
  input  wire logic [1:0] config_index,
  input  wire logic [4:0] config_data,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [1:0] op,
  input  wire logic [7:0] status_byte,
  input  wire logic [6:0] data_one,
  input  wire logic [6:0] data_two,
  input  wire logic [2:0] map_action,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [2:0]      transport_action
);

  mtcm_pkg::cfg_t              cfg;
  mtcm_pkg::item_t             item;
  mtcm_pkg::result_t           result;
  logic                        item_valid;
  logic                        item_advance;
  logic                        accept;
  logic                        key_wr;
  logic                        ctl_wr;
  logic [mtcm_pkg::EntryW-1:0] key_entry;
  logic [mtcm_pkg::EntryW-1:0] ctl_entry;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.listen_enable    <= 1'b0;
      cfg.channel_filter   <= mtcm_pkg::FILTER_ALL;
      cfg.require_modifier <= 1'b1;
    end else if (config_write) begin
      case (config_index)
        mtcm_pkg::CFG_LISTEN_ENABLE:    cfg.listen_enable    <= config_data[0];
        mtcm_pkg::CFG_CHANNEL_FILTER:   cfg.channel_filter   <= $signed(config_data);
        mtcm_pkg::CFG_REQUIRE_MODIFIER: cfg.require_modifier <= config_data[0];
        default: ;
      endcase
    end
  end

  // handshake: the item stage moves unless its result meets a stalled output
  assign item_advance = !result.fire || !out_valid || !out_stall;
  assign in_stall     = item_valid && !item_advance;
  assign accept       = in_valid && !in_stall;
  assign key_wr       = accept && (mtcm_pkg::op_t'(op) == mtcm_pkg::OP_KEY_WR);
  assign ctl_wr       = accept && (mtcm_pkg::op_t'(op) == mtcm_pkg::OP_CTL_WR);

  // action tables
  mtcm_table u_key_table (
    .clk        (clk),
    .rst        (rst),
    .wr_en      (key_wr),
    .wr_addr    (data_one),
    .wr_data    (map_action),
    .rd_en      (accept),
    .rd_addr    (data_one),
    .rd_default (mtcm_pkg::key_reset_entry(data_one)),
    .rd_data    (key_entry)
  );

  mtcm_table u_ctl_table (
    .clk        (clk),
    .rst        (rst),
    .wr_en      (ctl_wr),
    .wr_addr    (data_one),
    .wr_data    (map_action),
    .rd_en      (accept),
    .rd_addr    (data_one),
    .rd_default (mtcm_pkg::ctl_reset_entry(data_one)),
    .rd_data    (ctl_entry)
  );

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (accept) begin
      item_valid <= 1'b1;
    end else if (item_advance) begin
      item_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item.op          <= mtcm_pkg::op_t'(op);
      item.status_byte <= status_byte;
      item.data_two    <= data_two;
    end
  end

  // decision and modifier count
  mtcm_eval u_eval (
    .clk       (clk),
    .rst       (rst),
    .advance   (item_valid && item_advance),
    .item      (item),
    .key_entry (key_entry),
    .ctl_entry (ctl_entry),
    .cfg       (cfg),
    .result    (result)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (item_valid && item_advance && result.fire) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && item_advance && result.fire) begin
      transport_action <= result.action;
    end
  end

  // checks
  a_stall_needs_item: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> item_valid)
    else $error("input stalled with no item in flight");

  a_blocked_result_stalls: assert property (@(posedge clk) disable iff (rst)
    (item_valid && result.fire && out_valid && out_stall) |-> in_stall)
    else $error("pending result not protected by input stall");

  a_fire_needs_listen: assert property (@(posedge clk) disable iff (rst)
    (item_valid && result.fire) |-> (cfg.listen_enable && item.op == mtcm_pkg::OP_MIDI))
    else $error("action produced without listening midi message");

  a_reset_clears_out: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid right after reset");

endmodule

`default_nettype wire

// File: verif/midi_transport_command_mapper_core_test.sv
`default_nettype none

module midi_transport_command_mapper_core_test;
  import mtcm_pkg::*;

  localparam int CycleLimit = 400000;
  localparam int LongHold   = 120;

  // expected transport actions, with a private copy of tables, modifier count and settings
  class action_scoreboard;
    logic [EntryW-1:0] key_map [TableDepth];
    logic [EntryW-1:0] ctl_map [TableDepth];
    logic [7:0]        held_mods;
    cfg_t              cfg;
    logic [2:0]        pending_actions [$];
    int                errors;
    int                checked;

    function new();
      errors  = 0;
      checked = 0;
      for (int i = 0; i < TableDepth; i++) begin
        key_map[i] = ACT_NONE;
        ctl_map[i] = ACT_NONE;
      end
      key_map[KEY_MODIFIER]    = ACT_CONTROL;
      key_map[KEY_PLAY]        = ACT_PLAY;
      key_map[KEY_STOP]        = ACT_STOP;
      key_map[KEY_TOGGLE_LOOP] = ACT_TOGGLE_LOOP;
      ctl_map[CTL_PLAY]        = ACT_PLAY;
      ctl_map[CTL_STOP]        = ACT_STOP;
      held_mods                = 8'd0;
      cfg.listen_enable        = 1'b0;
      cfg.channel_filter       = FILTER_ALL;
      cfg.require_modifier     = 1'b1;
    endfunction

    // one line per mismatch, counted
    task report_mismatch(string msg);
      errors++;
      $display("mismatch: %s", msg);
    endtask

    function void set_register(logic [1:0] idx, logic [4:0] data);
      case (idx)
        CFG_LISTEN_ENABLE:    cfg.listen_enable    = data[0];
        CFG_CHANNEL_FILTER:   cfg.channel_filter   = data;
        CFG_REQUIRE_MODIFIER: cfg.require_modifier = data[0];
        default: ;
      endcase
    endfunction

    // entries play through loop end map onto transport codes, the rest fire nothing
    function void fire(logic [EntryW-1:0] entry);
      if (entry >= ACT_PLAY && entry <= ACT_LOOP_END) begin
        pending_actions.push_back(entry - ACT_PLAY);
      end
    endfunction

    function void predict_item(op_t item_op, logic [7:0] st, logic [6:0] d1,
                               logic [6:0] d2, logic [2:0] act);
      logic [3:0]        kind;
      logic [4:0]        filt;
      logic [EntryW-1:0] entry;
      kind = st[7:4];
      filt = cfg.channel_filter;
      case (item_op)
        OP_KEY_WR: key_map[d1] = act;
        OP_CTL_WR: ctl_map[d1] = act;
        OP_MIDI: begin
          if (cfg.listen_enable && (filt == FILTER_ALL || filt == {1'b0, st[3:0]})) begin
            if (kind == KIND_NOTE_ON) begin
              entry = key_map[d1];
              // modifier keys count up on press, down on zero velocity
              if (entry == ACT_CONTROL) begin
                if (d2 != 7'd0) begin
                  if (held_mods != 8'hFF) held_mods++;
                end else if (held_mods != 8'd0) begin
                  held_mods--;
                end
              end else if (d2 != 7'd0 && (!cfg.require_modifier || held_mods != 8'd0)) begin
                fire(entry);
              end
            end else if (kind == KIND_CTRL_CHG && d2 != 7'd0) begin
              fire(ctl_map[d1]);
            end
          end
        end
        default: ;
      endcase
    endfunction

    task check_action(logic [2:0] got);
      logic [2:0] want;
      checked++;
      if (pending_actions.size() == 0) begin
        report_mismatch($sformatf("transport action %0d with none expected", got));
      end else begin
        want = pending_actions.pop_front();
        if (got !== want) begin
          report_mismatch($sformatf("transport action %0d, expected %0d", got, want));
        end
      end
    endtask
  endclass

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       config_write = 1'b0;
  logic [1:0] config_index = CFG_LISTEN_ENABLE;
  logic [4:0] config_data = 5'd0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [1:0] op = OP_MIDI;
  logic [7:0] status_byte = 8'd0;
  logic [6:0] data_one = 7'd0;
  logic [6:0] data_two = 7'd0;
  logic [2:0] map_action = 3'd0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [2:0] transport_action;

  action_scoreboard board;
  bit no_idle = 1'b0;
  int hold_requests = 0;
  int holds_seen = 0;
  int hold_left = 0;
  int stall_left = 0;
  int cycle_count = 0;
  int items_sent = 0;
  int settings_used = 0;

  midi_transport_command_mapper_core DUT (
    .clk              (clk),
    .rst              (rst),
    .config_write     (config_write),
    .config_index     (config_index),
    .config_data      (config_data),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .op               (op),
    .status_byte      (status_byte),
    .data_one         (data_one),
    .data_two         (data_two),
    .map_action       (map_action),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .transport_action (transport_action)
  );

  // clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // receiver: check each result transaction, then random stall or a long hold-off
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall) begin
        board.check_action(transport_action);
        stall_left = no_idle ? 0 : $urandom_range(0, 3);
      end
      if (holds_seen != hold_requests) begin
        holds_seen = hold_requests;
        hold_left  = LongHold;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // one input transaction after a random gap; valid stays up for back-to-back items
  task automatic send_item(op_t item_op, logic [7:0] st, logic [6:0] d1,
                           logic [6:0] d2, logic [2:0] act);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    op          <= item_op;
    status_byte <= st;
    data_one    <= d1;
    data_two    <= d2;
    map_action  <= act;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    board.predict_item(item_op, st, d1, d2, act);
    items_sent++;
  endtask

  task automatic midi(logic [3:0] kind, logic [3:0] ch, logic [6:0] d1, logic [6:0] d2);
    send_item(OP_MIDI, {kind, ch}, d1, d2, 3'($urandom));
  endtask

  task automatic table_write(op_t item_op, logic [6:0] idx, logic [2:0] act);
    send_item(item_op, 8'($urandom), idx, 7'($urandom), act);
  endtask

  // sender pause until every expected action is out and the pipeline is empty
  task automatic drain_pipeline();
    in_valid <= 1'b0;
    @(posedge clk);
    while (board.pending_actions.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [4:0] data);
    config_write <= 1'b1;
    config_index <= idx;
    config_data  <= data;
    @(posedge clk);
    board.set_register(idx, data);
  endtask

  // all three registers, unused bits of the one-bit ones random
  task automatic configure(logic listen, logic [4:0] filt, logic req);
    drain_pipeline();
    write_reg(CFG_LISTEN_ENABLE, {4'($urandom), listen});
    write_reg(CFG_CHANNEL_FILTER, filt);
    write_reg(CFG_REQUIRE_MODIFIER, {4'($urandom), req});
    config_write <= 1'b0;
    @(posedge clk);
    settings_used++;
  endtask

  // mostly preset and edge table locations, sometimes anywhere
  function automatic logic [6:0] pick_index();
    logic [6:0] idx;
    case ($urandom_range(0, 15))
      0:       idx = 7'd0;
      1:       idx = 7'd1;
      2:       idx = 7'd127;
      3:       idx = CTL_PLAY;
      4:       idx = CTL_STOP;
      5:       idx = KEY_PLAY;
      6:       idx = KEY_STOP;
      7:       idx = KEY_TOGGLE_LOOP;
      8, 9:    idx = KEY_MODIFIER;
      default: idx = 7'($urandom);
    endcase
    return idx;
  endfunction

  task automatic send_random_item();
    int         roll;
    logic [4:0] filt;
    logic [3:0] ch;
    logic [6:0] d1;
    logic [6:0] d2;
    roll = $urandom_range(0, 99);
    filt = board.cfg.channel_filter;
    ch   = (!filt[4] && $urandom_range(0, 3) != 0) ? filt[3:0] : 4'($urandom);
    d1   = pick_index();
    case ($urandom_range(0, 3))
      0:       d2 = 7'd0;
      1:       d2 = 7'd127;
      default: d2 = 7'($urandom);
    endcase
    if (roll < 8) begin
      table_write(OP_KEY_WR, d1, 3'($urandom));
    end else if (roll < 13) begin
      table_write(OP_CTL_WR, d1, 3'($urandom));
    end else if (roll < 16) begin
      send_item(OP_UNUSED, 8'($urandom), 7'($urandom), 7'($urandom), 3'($urandom));
    end else if (roll < 22) begin
      send_item(OP_MIDI, 8'($urandom), 7'($urandom), 7'($urandom), 3'($urandom));
    end else if (roll < 62) begin
      midi(KIND_NOTE_ON, ch, d1, d2);
    end else if (roll < 70) begin
      midi(KIND_NOTE_OFF, ch, d1, d2);
    end else begin
      midi(KIND_CTRL_CHG, ch, d1, d2);
    end
  endtask

  initial begin
    logic [4:0] filt;
    board = new();
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // listening off: messages do nothing, table writes still land
    midi(KIND_NOTE_ON, 4'd0, KEY_PLAY, 7'd100);
    table_write(OP_KEY_WR, 7'd127, 3'd7);
    configure(1'b1, FILTER_ALL, 1'b1);

    // preset keys and controllers, modifier required
    midi(KIND_NOTE_ON, 4'd0, KEY_PLAY, 7'd100);
    midi(KIND_NOTE_ON, 4'd3, KEY_MODIFIER, 7'd127);
    midi(KIND_NOTE_ON, 4'd0, KEY_PLAY, 7'd127);
    midi(KIND_NOTE_ON, 4'd15, KEY_STOP, 7'd1);
    midi(KIND_NOTE_ON, 4'd7, KEY_TOGGLE_LOOP, 7'd127);
    midi(KIND_NOTE_ON, 4'd0, KEY_PLAY, 7'd0);
    midi(KIND_NOTE_OFF, 4'd0, KEY_PLAY, 7'd127);
    midi(KIND_CTRL_CHG, 4'd15, CTL_PLAY, 7'd127);
    midi(KIND_CTRL_CHG, 4'd0, CTL_STOP, 7'd1);
    midi(KIND_CTRL_CHG, 4'd0, CTL_STOP, 7'd0);
    midi(KIND_CTRL_CHG, 4'd0, 7'd0, 7'd127);
    // table rewrites, the unused entry code, control entry on a controller
    table_write(OP_KEY_WR, 7'd0, ACT_LOOP_START);
    midi(KIND_NOTE_ON, 4'd2, 7'd0, 7'd64);
    midi(KIND_NOTE_ON, 4'd2, 7'd127, 7'd127);
    table_write(OP_KEY_WR, 7'd127, ACT_LOOP_END);
    midi(KIND_NOTE_ON, 4'd2, 7'd127, 7'd127);
    table_write(OP_CTL_WR, 7'd127, 3'd7);
    midi(KIND_CTRL_CHG, 4'd9, 7'd127, 7'd127);
    table_write(OP_CTL_WR, 7'd0, ACT_CONTROL);
    midi(KIND_CTRL_CHG, 4'd9, 7'd0, 7'd5);
    // other message kinds and the unused op
    send_item(OP_MIDI, 8'hA5, KEY_PLAY, 7'd127, 3'd0);
    send_item(OP_MIDI, 8'hFF, 7'd127, 7'd127, 3'd7);
    send_item(OP_UNUSED, 8'h9F, KEY_PLAY, 7'd127, 3'd7);
    // release modifier twice: count floors at zero
    midi(KIND_NOTE_ON, 4'd3, KEY_MODIFIER, 7'd0);
    midi(KIND_NOTE_ON, 4'd3, KEY_MODIFIER, 7'd0);
    midi(KIND_NOTE_ON, 4'd0, KEY_PLAY, 7'd127);

    // modifier count saturation and return to zero
    configure(1'b1, FILTER_ALL, 1'b1);
    table_write(OP_KEY_WR, KEY_MODIFIER, ACT_CONTROL);
    table_write(OP_KEY_WR, KEY_PLAY, ACT_PLAY);
    repeat (260) midi(KIND_NOTE_ON, 4'($urandom), KEY_MODIFIER, 7'($urandom_range(1, 127)));
    midi(KIND_NOTE_ON, 4'd0, KEY_PLAY, 7'd100);
    repeat (255) midi(KIND_NOTE_ON, 4'($urandom), KEY_MODIFIER, 7'd0);
    midi(KIND_NOTE_ON, 4'd0, KEY_PLAY, 7'd100);
    midi(KIND_NOTE_ON, 4'd0, KEY_MODIFIER, 7'd0);
    midi(KIND_NOTE_ON, 4'd0, KEY_PLAY, 7'd100);

    // random phases over filter extremes, out-of-range filters and listening off
    for (int phase = 0; phase < 8; phase++) begin
      case (phase)
        0:       filt = FILTER_ALL;
        1:       filt = 5'd0;
        2:       filt = 5'd15;
        3:       filt = 5'h10;
        4:       filt = 5'($urandom_range(0, 15));
        5:       filt = 5'h1E;
        6:       filt = FILTER_ALL;
        default: filt = 5'($urandom);
      endcase
      configure(phase != 6, filt, phase[0]);
      if (phase == 2) begin
        // output held off while input keeps offering actions
        table_write(OP_CTL_WR, CTL_PLAY, ACT_PLAY);
        hold_requests++;
        no_idle = 1'b1;
        repeat (40) midi(KIND_CTRL_CHG, 4'd15, CTL_PLAY, 7'($urandom_range(1, 127)));
        no_idle = 1'b0;
        drain_pipeline();
      end
      no_idle = (phase == 4);
      repeat (170) send_random_item();
      no_idle = 1'b0;
    end

    drain_pipeline();
    repeat (6) @(posedge clk);
    $display("run covered %0d transactions over %0d register settings, %0d actions checked",
             items_sent, settings_used, board.checked);
    $display("including modifier saturation, table rewrites and a %0d-cycle output hold-off",
             LongHold);
    if (board.errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire
